FILE: rtl/core/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Shared widths, request codes and opcodes of the accumulator processor step.
// ----------------------------------------------------------------------------
package acs_pkg;

  // memory geometry
  localparam int MEM_WORDS = 32;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int PC_W      = ADDR_W + 1;
  localparam int WORD_W    = 8;
  localparam int OPC_W     = 3;
  localparam int REQ_W     = 2;

  // request codes of an input beat
  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXEC    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd3;

  // instruction opcodes, bits 7-5 of a word
  localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OPC_W-1:0] OP_INC    = 3'd1;
  localparam logic [OPC_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OPC_W-1:0] OP_DEC    = 3'd3;
  localparam logic [OPC_W-1:0] OP_JUMP   = 3'd4;
  localparam logic [OPC_W-1:0] OP_BRANCH = 3'd5;
  localparam logic [OPC_W-1:0] OP_LOAD   = 3'd6;
  localparam logic [OPC_W-1:0] OP_STORE  = 3'd7;

endpackage

FILE: rtl/core/acs_ram.sv
// ----------------------------------------------------------------------------
// acs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/accumulator_cpu_step.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// Accumulator processor with a 32-word unified memory, one request per beat.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle while the result register can drain and no
// load waits on its operand, and returns one result beat for each. A load
// instruction, unlike the other requests, holds the single pipeline stage for
// an extra operand phase, since the one RAM read port first fetches the
// instruction and then reads the operand word. The RAM is read in the cycle
// a beat is accepted (the fetch address is the program counter as updated by
// the beat retiring in that same cycle), and writes retire together with
// their beat; a read of the address written in the same cycle is forwarded.
// Per-word valid bits, cleared by reset, make memory read as zero until
// written, so no clearing pass is needed. An output register holds the result
// so that a new beat is taken while the previous result waits on out_ready.
module accumulator_cpu_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [acs_pkg::REQ_W-1:0]     in_req_type,
  input  logic [acs_pkg::ADDR_W-1:0]    in_mem_address,
  input  logic [acs_pkg::WORD_W-1:0]    in_write_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [acs_pkg::WORD_W-1:0]    out_read_word,
  output logic [acs_pkg::PC_W-1:0]      out_program_counter,
  output logic [acs_pkg::WORD_W-1:0]    out_data_value,
  output logic                          out_zero_flag,
  output logic                          out_halted
);

  // architectural state
  logic [acs_pkg::PC_W-1:0]      pc_r, pc_nxt;
  logic [acs_pkg::WORD_W-1:0]    acc_r, acc_nxt;
  logic [acs_pkg::MEM_WORDS-1:0] vld_r;

  // execute stage
  logic                          s1_vld_r;
  logic [acs_pkg::REQ_W-1:0]     s1_type_r;
  logic [acs_pkg::ADDR_W-1:0]    s1_addr_r;
  logic [acs_pkg::WORD_W-1:0]    s1_wdata_r;
  logic                          s1_ph_r;

  // read side bookkeeping
  logic                          rd_ok_r;
  logic                          rd_fwd_r;
  logic [acs_pkg::WORD_W-1:0]    rd_fwd_data_r;
  logic [acs_pkg::WORD_W-1:0]    ram_rdata;
  logic [acs_pkg::WORD_W-1:0]    rd_eff;

  // output register
  logic                          out_valid_r;
  logic [acs_pkg::WORD_W-1:0]    out_read_word_r;
  logic [acs_pkg::PC_W-1:0]      out_pc_r;
  logic [acs_pkg::WORD_W-1:0]    out_acc_r;
  logic                          out_zero_r;
  logic                          out_halted_r;

  // control
  logic                          in_fire;
  logic                          out_free;
  logic                          retire;
  logic                          need_load;
  logic                          wen_raw;
  logic                          wen;
  logic [acs_pkg::ADDR_W-1:0]    waddr;
  logic [acs_pkg::WORD_W-1:0]    wdata;
  logic                          ren;
  logic [acs_pkg::ADDR_W-1:0]    raddr;
  logic [acs_pkg::WORD_W-1:0]    rword;
  logic [acs_pkg::OPC_W-1:0]     opc;
  logic [acs_pkg::ADDR_W-1:0]    opd;
  logic [acs_pkg::PC_W-1:0]      pc_inc;
  logic                          halted_now;
  logic [acs_pkg::PC_W-1:0]      pc_fetch;

  // resolve the word read last cycle: forwarded, stored, or never written
  always_comb begin
    if (rd_fwd_r) begin
      rd_eff = rd_fwd_data_r;
    end else if (rd_ok_r) begin
      rd_eff = ram_rdata;
    end else begin
      rd_eff = '0;
    end
  end

  assign opc        = rd_eff[acs_pkg::WORD_W-1 -: acs_pkg::OPC_W];
  assign opd        = rd_eff[acs_pkg::ADDR_W-1:0];
  assign pc_inc     = pc_r + acs_pkg::PC_W'(1);
  assign halted_now = pc_r[acs_pkg::PC_W-1];

  assign need_load = s1_vld_r && (s1_type_r == acs_pkg::REQ_EXEC) && !halted_now
                     && !s1_ph_r && (opc == acs_pkg::OP_LOAD);
  assign out_free  = !out_valid_r || out_ready;
  assign retire    = s1_vld_r && out_free && !need_load;
  assign in_ready  = !s1_vld_r || retire;
  assign in_fire   = in_valid && in_ready;

  // execute the held beat
  always_comb begin
    pc_nxt  = pc_r;
    acc_nxt = acc_r;
    wen_raw = 1'b0;
    waddr   = s1_addr_r;
    wdata   = s1_wdata_r;
    rword   = '0;
    unique case (s1_type_r)
      acs_pkg::REQ_WRITE: begin
        wen_raw = 1'b1;
      end
      acs_pkg::REQ_READ: begin
        rword = rd_eff;
      end
      acs_pkg::REQ_EXEC: begin
        if (!halted_now) begin
          pc_nxt = pc_inc;
          if (s1_ph_r) begin
            // second phase of a load: operand word has arrived
            acc_nxt = rd_eff;
          end else begin
            unique case (opc)
              acs_pkg::OP_CLEAR:  acc_nxt = '0;
              acs_pkg::OP_INC:    acc_nxt = acc_r + acs_pkg::WORD_W'(1);
              acs_pkg::OP_ADD:    acc_nxt = acc_r + acs_pkg::WORD_W'(opd);
              acs_pkg::OP_DEC:    acc_nxt = acc_r - acs_pkg::WORD_W'(1);
              acs_pkg::OP_JUMP:   pc_nxt = acs_pkg::PC_W'(opd);
              acs_pkg::OP_BRANCH: begin
                if (acc_r != '0) begin
                  pc_nxt = acs_pkg::PC_W'(opd);
                end
              end
              acs_pkg::OP_LOAD:   acc_nxt = acc_r;
              acs_pkg::OP_STORE:  begin
                wen_raw = 1'b1;
                waddr   = opd;
                wdata   = acc_r;
              end
            endcase
          end
        end
      end
      acs_pkg::REQ_RESTART: begin
        pc_nxt  = '0;
        acc_nxt = '0;
      end
    endcase
  end

  assign wen = retire && wen_raw;

  // pick the read address: operand of a load, or the accepted beat's word
  assign pc_fetch = retire ? pc_nxt : pc_r;
  assign ren      = need_load || in_fire;
  always_comb begin
    if (need_load) begin
      raddr = opd;
    end else if (in_req_type == acs_pkg::REQ_READ) begin
      raddr = in_mem_address;
    end else begin
      raddr = pc_fetch[acs_pkg::ADDR_W-1:0];
    end
  end

  acs_ram #(
    .WIDTH (acs_pkg::WORD_W),
    .DEPTH (acs_pkg::MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (wen),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ren),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // capture read qualifiers, forwarding a same-cycle write
  always_ff @(posedge clk) begin
    if (ren) begin
      rd_fwd_r      <= wen && (waddr == raddr);
      rd_fwd_data_r <= wdata;
      rd_ok_r       <= vld_r[raddr] || (wen && (waddr == raddr));
    end
  end

  // word valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wen) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // stage control and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_ph_r  <= 1'b0;
      pc_r     <= '0;
      acc_r    <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
        s1_ph_r  <= 1'b0;
      end else if (retire) begin
        s1_vld_r <= 1'b0;
        s1_ph_r  <= 1'b0;
      end else if (need_load) begin
        s1_ph_r <= 1'b1;
      end
      if (retire) begin
        pc_r  <= pc_nxt;
        acc_r <= acc_nxt;
      end
    end
  end

  // hold the accepted beat's payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type_r  <= in_req_type;
      s1_addr_r  <= in_mem_address;
      s1_wdata_r <= in_write_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (retire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_read_word_r <= rword;
      out_pc_r        <= pc_nxt;
      out_acc_r       <= acc_nxt;
      out_zero_r      <= (acc_nxt == '0);
      out_halted_r    <= pc_nxt[acs_pkg::PC_W-1];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_word       = out_read_word_r;
  assign out_program_counter = out_pc_r;
  assign out_data_value      = out_acc_r;
  assign out_zero_flag       = out_zero_r;
  assign out_halted          = out_halted_r;

`ifndef SYNTHESIS
  // a load issue moves the stage into its operand phase
  a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
    need_load |=> (s1_vld_r && s1_ph_r))
    else $error("load issue did not enter operand phase");

  // operand phase only for a running execute beat
  a_phase_exec: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ph_r |-> (s1_vld_r && (s1_type_r == acs_pkg::REQ_EXEC) && !halted_now))
    else $error("operand phase outside an execute beat");

  // a retiring beat always lands in the result register
  a_retire_out: assert property (@(posedge clk) disable iff (!rst_n)
    retire |=> out_valid_r)
    else $error("retired beat lost");

  // program counter never passes the end of memory
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    halted_now |-> (pc_r[acs_pkg::ADDR_W-1:0] == '0))
    else $error("program counter beyond end of memory");

  // halted flag agrees with the reported program counter
  a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_halted_r == out_pc_r[acs_pkg::PC_W-1]))
    else $error("halted flag disagrees with program counter");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accumulator processor step.
// ----------------------------------------------------------------------------
// A short table of directed requests comes first. It loads a program that
// uses every opcode, runs it off the end of memory, steps while halted and
// then restarts. After that come random episodes: load a few words, mostly
// restart, and step the program with reads, writes and restarts mixed in.
// A shadow copy of the machine predicts every result beat. Both handshakes
// idle at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DIRECTED_ROWS = 26;
  localparam int RANDOM_ITEMS  = 600;
  localparam int MAX_IDLE      = 14;
  localparam int TAIL_CYCLES   = 8;

  typedef struct packed {
    logic [acs_pkg::WORD_W-1:0] read_word;
    logic [acs_pkg::PC_W-1:0]   program_counter;
    logic [acs_pkg::WORD_W-1:0] data_value;
    logic                       zero_flag;
    logic                       halted;
  } machine_view_t;

  typedef struct packed {
    logic [acs_pkg::REQ_W-1:0]  req;
    logic [acs_pkg::ADDR_W-1:0] addr;
    logic [acs_pkg::WORD_W-1:0] word;
    logic                       pinned;
    machine_view_t              pinned_view;
  } plan_row_t;

  localparam machine_view_t FRESH_VIEW  = '{8'h00, 6'd0, 8'h00, 1'b1, 1'b0};
  localparam machine_view_t HALTED_VIEW = '{8'h00, 6'd32, 8'h00, 1'b1, 1'b1};
  localparam machine_view_t NO_VIEW     = '0;

  // Program: inc, add 31, dec, store 20, load 31, branch 7 (taken), clear,
  // branch 0 (not taken), jump 31, store 31, then off the end.
  plan_row_t directed_plan [0:DIRECTED_ROWS-1] = '{
    '{acs_pkg::REQ_READ,    5'd0,  8'h00, 1'b1, FRESH_VIEW},
    '{acs_pkg::REQ_READ,    5'd31, 8'h00, 1'b1, FRESH_VIEW},
    '{acs_pkg::REQ_WRITE,   5'd31, 8'hff, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_READ,    5'd31, 8'h00, 1'b1, '{8'hff, 6'd0, 8'h00, 1'b1, 1'b0}},
    '{acs_pkg::REQ_WRITE,   5'd0,  {acs_pkg::OP_INC, 5'd0},     1'b0, NO_VIEW},
    '{acs_pkg::REQ_WRITE,   5'd1,  {acs_pkg::OP_ADD, 5'd31},    1'b0, NO_VIEW},
    '{acs_pkg::REQ_WRITE,   5'd2,  {acs_pkg::OP_DEC, 5'd0},     1'b0, NO_VIEW},
    '{acs_pkg::REQ_WRITE,   5'd3,  {acs_pkg::OP_STORE, 5'd20},  1'b0, NO_VIEW},
    '{acs_pkg::REQ_WRITE,   5'd4,  {acs_pkg::OP_LOAD, 5'd31},   1'b0, NO_VIEW},
    '{acs_pkg::REQ_WRITE,   5'd5,  {acs_pkg::OP_BRANCH, 5'd7},  1'b0, NO_VIEW},
    '{acs_pkg::REQ_WRITE,   5'd7,  {acs_pkg::OP_CLEAR, 5'd0},   1'b0, NO_VIEW},
    '{acs_pkg::REQ_WRITE,   5'd8,  {acs_pkg::OP_BRANCH, 5'd0},  1'b0, NO_VIEW},
    '{acs_pkg::REQ_WRITE,   5'd9,  {acs_pkg::OP_JUMP, 5'd31},   1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b0, NO_VIEW},
    '{acs_pkg::REQ_EXEC,    5'd0,  8'h00, 1'b1, HALTED_VIEW},
    '{acs_pkg::REQ_READ,    5'd31, 8'h00, 1'b1, HALTED_VIEW},
    '{acs_pkg::REQ_RESTART, 5'd0,  8'h00, 1'b1, FRESH_VIEW}
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [acs_pkg::REQ_W-1:0]  in_req_type = acs_pkg::REQ_WRITE;
  logic [acs_pkg::ADDR_W-1:0] in_mem_address = '0;
  logic [acs_pkg::WORD_W-1:0] in_write_word = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [acs_pkg::WORD_W-1:0] out_read_word;
  logic [acs_pkg::PC_W-1:0]   out_program_counter;
  logic [acs_pkg::WORD_W-1:0] out_data_value;
  logic                       out_zero_flag;
  logic                       out_halted;

  // shadow machine state
  logic [acs_pkg::WORD_W-1:0] shadow_mem [0:acs_pkg::MEM_WORDS-1];
  logic [acs_pkg::PC_W-1:0]   shadow_pc;
  logic [acs_pkg::WORD_W-1:0] shadow_acc;

  machine_view_t pending_results [$];
  int            error_count = 0;
  bit            sender_calm = 1'b0;
  bit            receiver_calm = 1'b0;

  accumulator_cpu_step i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_mem_address      (in_mem_address),
    .in_write_word       (in_write_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_word       (out_read_word),
    .out_program_counter (out_program_counter),
    .out_data_value      (out_data_value),
    .out_zero_flag       (out_zero_flag),
    .out_halted          (out_halted)
  );

  always #1 clk = ~clk;

  // Apply one request to the shadow machine and report the state after it.
  task automatic step_machine(input logic [acs_pkg::REQ_W-1:0] req,
                              input logic [acs_pkg::ADDR_W-1:0] addr,
                              input logic [acs_pkg::WORD_W-1:0] word,
                              output machine_view_t view);
    logic [acs_pkg::WORD_W-1:0] fetched;
    logic [acs_pkg::ADDR_W-1:0] operand;
    logic [acs_pkg::PC_W-1:0]   pc_next;
    view.read_word = '0;
    case (req)
      acs_pkg::REQ_WRITE: shadow_mem[addr] = word;
      acs_pkg::REQ_READ:  view.read_word = shadow_mem[addr];
      acs_pkg::REQ_EXEC: begin
        // a halted machine ignores execute requests
        if (shadow_pc < acs_pkg::MEM_WORDS) begin
          fetched = shadow_mem[shadow_pc[acs_pkg::ADDR_W-1:0]];
          operand = fetched[acs_pkg::ADDR_W-1:0];
          pc_next = shadow_pc + acs_pkg::PC_W'(1);
          case (fetched[acs_pkg::WORD_W-1 -: acs_pkg::OPC_W])
            acs_pkg::OP_CLEAR:  shadow_acc = '0;
            acs_pkg::OP_INC:    shadow_acc = shadow_acc + acs_pkg::WORD_W'(1);
            acs_pkg::OP_ADD:    shadow_acc = shadow_acc + acs_pkg::WORD_W'(operand);
            acs_pkg::OP_DEC:    shadow_acc = shadow_acc - acs_pkg::WORD_W'(1);
            acs_pkg::OP_JUMP:   pc_next = acs_pkg::PC_W'(operand);
            acs_pkg::OP_BRANCH: if (shadow_acc != '0) pc_next = acs_pkg::PC_W'(operand);
            acs_pkg::OP_LOAD:   shadow_acc = shadow_mem[operand];
            acs_pkg::OP_STORE:  shadow_mem[operand] = shadow_acc;
          endcase
          shadow_pc = pc_next;
        end
      end
      acs_pkg::REQ_RESTART: begin
        shadow_pc  = '0;
        shadow_acc = '0;
      end
    endcase
    view.program_counter = shadow_pc;
    view.data_value      = shadow_acc;
    view.zero_flag       = (shadow_acc == '0);
    view.halted          = (shadow_pc >= acs_pkg::MEM_WORDS);
  endtask

  function automatic int draw_idle(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Drive one request beat; predict its result once it is accepted.
  task automatic send_request(input logic [acs_pkg::REQ_W-1:0] req,
                              input logic [acs_pkg::ADDR_W-1:0] addr,
                              input logic [acs_pkg::WORD_W-1:0] word,
                              input logic pinned,
                              input machine_view_t pinned_view);
    int            idle;
    machine_view_t predicted;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    idle = draw_idle(sender_calm);
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_mem_address <= addr;
    in_write_word  <= word;
    do @(posedge clk); while (!in_ready);
    step_machine(req, addr, word, predicted);
    pending_results.push_back(pinned ? pinned_view : predicted);
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [acs_pkg::ADDR_W-1:0] pick_address();
    // favor the low words, where random programs start
    return ($urandom_range(0, 1) == 0) ? acs_pkg::ADDR_W'($urandom_range(0, 7))
                                       : acs_pkg::ADDR_W'($urandom_range(0,
                                           acs_pkg::MEM_WORDS - 1));
  endfunction

  function automatic logic [acs_pkg::ADDR_W-1:0] any_address();
    return acs_pkg::ADDR_W'($urandom_range(0, acs_pkg::MEM_WORDS - 1));
  endfunction

  function automatic logic [acs_pkg::WORD_W-1:0] any_word();
    return acs_pkg::WORD_W'($urandom_range(0, 255));
  endfunction

  task automatic compare_field(input string name, input logic [acs_pkg::WORD_W-1:0] want,
                               input logic [acs_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    machine_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("read_word", want.read_word, out_read_word);
        compare_field("program_counter", acs_pkg::WORD_W'(want.program_counter),
                      acs_pkg::WORD_W'(out_program_counter));
        compare_field("data_value", want.data_value, out_data_value);
        compare_field("zero_flag", acs_pkg::WORD_W'(want.zero_flag),
                      acs_pkg::WORD_W'(out_zero_flag));
        compare_field("halted", acs_pkg::WORD_W'(want.halted),
                      acs_pkg::WORD_W'(out_halted));
      end
    end
  end

  // Result side: stall a random number of cycles before taking each beat.
  initial begin
    int idle;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
      idle = draw_idle(receiver_calm);
      @(negedge clk);
      if (idle > 0) begin
        out_ready <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #1_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int                        random_sent;
    int                        steps;
    int                        pick;
    logic [acs_pkg::REQ_W-1:0] req;
    for (int a = 0; a < acs_pkg::MEM_WORDS; a++) shadow_mem[a] = '0;
    shadow_pc   = '0;
    shadow_acc  = '0;
    random_sent = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_plan[r])
      send_request(directed_plan[r].req, directed_plan[r].addr, directed_plan[r].word,
                   directed_plan[r].pinned, directed_plan[r].pinned_view);
    drain_results();

    // random episodes: load words, mostly restart, then step the program
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) drain_results();
      repeat ($urandom_range(1, 10)) begin
        send_request(acs_pkg::REQ_WRITE, pick_address(), any_word(), 1'b0, NO_VIEW);
        random_sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        send_request(acs_pkg::REQ_RESTART, any_address(), any_word(), 1'b0, NO_VIEW);
        random_sent++;
      end
      steps = $urandom_range(4, 30);
      repeat (steps) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       req = acs_pkg::REQ_READ;
          1:       req = acs_pkg::REQ_WRITE;
          2:       req = acs_pkg::REQ_RESTART;
          default: req = acs_pkg::REQ_EXEC;
        endcase
        // mostly leave the halted state rather than poke at it
        if (req == acs_pkg::REQ_EXEC && shadow_pc >= acs_pkg::MEM_WORDS
            && $urandom_range(0, 3) != 0)
          req = acs_pkg::REQ_RESTART;
        if (!(req == acs_pkg::REQ_EXEC && shadow_pc >= acs_pkg::MEM_WORDS)) random_sent++;
        send_request(req, any_address(), any_word(), 1'b0, NO_VIEW);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
